FILE: rtl/ave_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ave_pkg
// Shared types, codes and encoding helpers of the AMQP value encoder.
// ----------------------------------------------------------------------------
package ave_pkg;

  localparam int unsigned MaxNestingDef  = 8;
  localparam int unsigned BufferBytesDef = 65536;
  localparam int unsigned DepthW         = 4;
  localparam int unsigned WposW          = 17;
  localparam int unsigned CmdBytes       = 10;

  typedef enum logic [3:0] {
    KIND_DESC  = 4'd0,
    KIND_NULL  = 4'd1,
    KIND_BOOL  = 4'd2,
    KIND_UINT  = 4'd3,
    KIND_ULONG = 4'd4,
    KIND_INT   = 4'd5,
    KIND_LONG  = 4'd6,
    KIND_TIME  = 4'd7,
    KIND_BIN   = 4'd8,
    KIND_STR   = 4'd9,
    KIND_SYM   = 4'd10,
    KIND_UUID  = 4'd11,
    KIND_RAW   = 4'd12,
    KIND_LIST  = 4'd13,
    KIND_MAP   = 4'd14,
    KIND_END   = 4'd15
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic        is_patch;
    logic [1:0]  status;
    logic        last;
  } out_t;

  // one classified transaction: bytes to emit, first byte in element 0
  typedef struct packed {
    logic [CmdBytes-1:0][7:0] bytes;
    logic [3:0]               n;
    logic [15:0]              base;
    logic                     patch;
    status_e                  status;
  } cmd_t;

  // one open composite
  typedef struct packed {
    logic [31:0] size;
    logic [31:0] count;
    logic [15:0] pos;
  } frame_t;

  typedef struct packed {
    logic [8:0][7:0] b;
    logic [3:0]      n;
  } ulong_t;

  // 64-bit value in big-endian byte order, most significant in element 0
  function automatic logic [7:0][7:0] be64(input logic [63:0] v);
    logic [7:0][7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [3:0][7:0] be32(input logic [31:0] v);
    logic [3:0][7:0] r;
    for (int i = 0; i < 4; i++) begin
      r[i] = v[8*(3-i) +: 8];
    end
    return r;
  endfunction

  // ulong in zero, small or full form
  function automatic ulong_t enc_ulong(input logic [63:0] v);
    ulong_t r;
    r.b = '0;
    if (v == 64'd0) begin
      r.b[0] = 8'h44;
      r.n    = 4'd1;
    end else if (v[63:8] == 56'd0) begin
      r.b[0] = 8'h53;
      r.b[1] = v[7:0];
      r.n    = 4'd2;
    end else begin
      r.b[0]   = 8'h80;
      r.b[8:1] = be64(v);
      r.n      = 4'd9;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ave_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ave_front
// Classifies each item, encodes its bytes and keeps position and frame stack.
// ----------------------------------------------------------------------------
module ave_front #(
  parameter int unsigned MAX_NESTING  = ave_pkg::MaxNestingDef,
  parameter int unsigned BUFFER_BYTES = ave_pkg::BufferBytesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         take_i,
  input  wire ave_pkg::in_t item_i,
  output ave_pkg::cmd_t     cmd_o
);

  localparam int unsigned ParentIdx = (MAX_NESTING > 1) ? 1 : 0;

  logic [ave_pkg::WposW-1:0]  wpos_q, wpos_d;
  logic [ave_pkg::DepthW-1:0] depth_q, depth_d;
  ave_pkg::frame_t            stack_q [MAX_NESTING];
  ave_pkg::frame_t            stack_d [MAX_NESTING];

  ave_pkg::kind_e  kind;
  logic [63:0]     v;
  logic [31:0]     u;
  ave_pkg::ulong_t ul;
  logic [ave_pkg::CmdBytes-1:0][7:0] b;
  logic [3:0]      n;
  logic            counts;
  logic            is_start;
  logic [17:0]     wend;
  ave_pkg::frame_t top_upd;

  assign kind     = ave_pkg::kind_e'(item_i.kind);
  assign v        = item_i.value;
  assign u        = item_i.value[31:0];
  assign ul       = ave_pkg::enc_ulong(v);
  assign is_start = (kind == ave_pkg::KIND_LIST) || (kind == ave_pkg::KIND_MAP);

  // byte encoding of non-end items
  always_comb begin
    b      = '0;
    n      = 4'd1;
    counts = 1'b1;
    case (kind)
      ave_pkg::KIND_DESC: begin
        b[9:1] = ul.b;
        n      = ul.n + 4'd1;
        counts = 1'b0;
      end
      ave_pkg::KIND_NULL: b[0] = 8'h40;
      ave_pkg::KIND_BOOL: b[0] = (v != 64'd0) ? 8'h41 : 8'h42;
      ave_pkg::KIND_UINT: begin
        if (u == 32'd0) begin
          b[0] = 8'h43;
        end else if (u[31:8] == 24'd0) begin
          b[0] = 8'h52;
          b[1] = u[7:0];
          n    = 4'd2;
        end else begin
          b[0]   = 8'h70;
          b[4:1] = ave_pkg::be32(u);
          n      = 4'd5;
        end
      end
      ave_pkg::KIND_ULONG: begin
        b[8:0] = ul.b;
        n      = ul.n;
      end
      ave_pkg::KIND_INT: begin
        if (&u[31:7] || ~|u[31:7]) begin
          b[0] = 8'h54;
          b[1] = u[7:0];
          n    = 4'd2;
        end else begin
          b[0]   = 8'h71;
          b[4:1] = ave_pkg::be32(u);
          n      = 4'd5;
        end
      end
      ave_pkg::KIND_LONG: begin
        if (&v[63:7] || ~|v[63:7]) begin
          b[0] = 8'h55;
          b[1] = v[7:0];
          n    = 4'd2;
        end else begin
          b[0]   = 8'h81;
          b[8:1] = ave_pkg::be64(v);
          n      = 4'd9;
        end
      end
      ave_pkg::KIND_TIME: begin
        b[0]   = 8'h83;
        b[8:1] = ave_pkg::be64(v);
        n      = 4'd9;
      end
      ave_pkg::KIND_BIN, ave_pkg::KIND_STR, ave_pkg::KIND_SYM: begin
        // low nibble of the constructor picks the family
        if (u[31:8] == 24'd0) begin
          b[0] = (kind == ave_pkg::KIND_BIN) ? 8'hA0 :
                 (kind == ave_pkg::KIND_STR) ? 8'hA1 : 8'hA3;
          b[1] = u[7:0];
          n    = 4'd2;
        end else begin
          b[0]   = (kind == ave_pkg::KIND_BIN) ? 8'hB0 :
                   (kind == ave_pkg::KIND_STR) ? 8'hB1 : 8'hB3;
          b[4:1] = ave_pkg::be32(u);
          n      = 4'd5;
        end
      end
      ave_pkg::KIND_UUID: b[0] = 8'h98;
      ave_pkg::KIND_RAW: begin
        b[0]   = v[7:0];
        counts = 1'b0;
      end
      default: begin
        b[0]   = (kind == ave_pkg::KIND_MAP) ? 8'hD1 : 8'hD0;
        n      = 4'd9;
        counts = 1'b0;
      end
    endcase
  end

  assign wend = {1'b0, wpos_q} + {14'd0, n};

  // innermost frame after this item's bytes
  always_comb begin
    top_upd      = stack_q[0];
    top_upd.size = stack_q[0].size + {28'd0, n};
    if (counts) begin
      top_upd.count = stack_q[0].count + 32'd1;
    end
  end

  // command and next state
  always_comb begin
    cmd_o.bytes  = b;
    cmd_o.n      = n;
    cmd_o.base   = wpos_q[15:0];
    cmd_o.patch  = 1'b0;
    cmd_o.status = ave_pkg::ST_OK;
    wpos_d       = wpos_q;
    depth_d      = depth_q;
    for (int i = 0; i < MAX_NESTING; i++) begin
      stack_d[i] = stack_q[i];
    end
    if (kind == ave_pkg::KIND_END) begin
      if (depth_q == '0) begin
        cmd_o.status = ave_pkg::ST_UNDERFLOW;
      end else begin
        cmd_o.bytes[3:0] = ave_pkg::be32(stack_q[0].size);
        cmd_o.bytes[7:4] = ave_pkg::be32(stack_q[0].count);
        cmd_o.bytes[9:8] = '0;
        cmd_o.n          = 4'd8;
        cmd_o.base       = stack_q[0].pos;
        cmd_o.patch      = 1'b1;
        depth_d          = depth_q - 1'b1;
        for (int i = 0; i < MAX_NESTING; i++) begin
          stack_d[i] = stack_q[(i + 1 < MAX_NESTING) ? i + 1 : i];
        end
        // fold inner content into the enclosing frame
        stack_d[0].size  = stack_q[ParentIdx].size + stack_q[0].size - 32'd4;
        stack_d[0].count = stack_q[ParentIdx].count + 32'd1;
      end
    end else if (is_start && ({28'd0, depth_q} >= MAX_NESTING)) begin
      cmd_o.status = ave_pkg::ST_OVERFLOW;
    end else if ({14'd0, wend} > BUFFER_BYTES) begin
      cmd_o.status = ave_pkg::ST_FULL;
    end else begin
      wpos_d = wend[ave_pkg::WposW-1:0];
      if (depth_q != '0) begin
        stack_d[0] = top_upd;
      end
      if (is_start) begin
        depth_d = depth_q + 1'b1;
        for (int i = 1; i < MAX_NESTING; i++) begin
          stack_d[i] = stack_q[i-1];
        end
        if (MAX_NESTING > 1) begin
          stack_d[ParentIdx] = top_upd;
        end
        stack_d[0].size  = 32'd4;
        stack_d[0].count = 32'd0;
        stack_d[0].pos   = wpos_q[15:0] + 16'd1;
      end
    end
    // errors emit a single zero byte
    if (cmd_o.status != ave_pkg::ST_OK) begin
      cmd_o.bytes = '0;
      cmd_o.n     = 4'd1;
      cmd_o.base  = wpos_q[15:0];
      cmd_o.patch = 1'b0;
    end
  end

  // position and depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q  <= '0;
      depth_q <= '0;
    end else if (take_i) begin
      wpos_q  <= wpos_d;
      depth_q <= depth_d;
    end
  end

  // frame stack, top in entry 0
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      for (int i = 0; i < MAX_NESTING; i++) begin
        stack_q[i] <= stack_d[i];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ave_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ave_fifo
// Two-entry command queue between the front and the byte emitter.
// ----------------------------------------------------------------------------
module ave_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire ave_pkg::cmd_t wdata_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output ave_pkg::cmd_t      rdata_o,
  output logic               avail_o
);

  ave_pkg::cmd_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q[1];
  assign avail_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) wptr_q <= ~wptr_q;
      if (rd_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ave_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ave_back
// Byte emitter: walks each command into out_q, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module ave_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ave_pkg::cmd_t cmd_i,
  input  wire logic          avail_i,
  output logic               done_o,
  output ave_pkg::out_t      out_o,
  output logic               empty_o,
  input  wire logic          pop_i
);

  logic [3:0]    idx_q;
  logic          vld_q;
  ave_pkg::out_t out_q;
  logic          load;
  logic          is_last;

  assign load    = avail_i && (!vld_q || pop_i);
  assign is_last = (idx_q + 4'd1) == cmd_i.n;
  assign done_o  = load && is_last;
  assign out_o   = out_q;
  assign empty_o = !vld_q;

  // byte index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
        vld_q <= 1'b1;
      end else if (pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // output transaction
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.data_byte   <= cmd_i.bytes[idx_q];
      out_q.byte_offset <= cmd_i.base + {12'd0, idx_q};
      out_q.is_patch    <= cmd_i.patch;
      out_q.status      <= cmd_i.status;
      out_q.last        <= is_last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/amqp_value_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amqp_value_encoder
// Encodes typed items into AMQP 1.0 bytes with offsets and size patches.
// ----------------------------------------------------------------------------
// channel   ports                    transaction when
// input     push full in_i           push && !full
// result    empty pop out_o          pop && !empty
//
// the front takes one item a cycle while the two-entry queue has room
// the emitter gives one byte a cycle unless pop stalls it; an item holds it until its last byte is loaded
// the first byte of a taken item is registered in the queue and then in out_q before the result ports show it
// reset clears position, depth and queues; the frame stack needs no clearing
// ----------------------------------------------------------------------------
module amqp_value_encoder #(
  parameter int unsigned MAX_NESTING  = ave_pkg::MaxNestingDef,
  parameter int unsigned BUFFER_BYTES = ave_pkg::BufferBytesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire ave_pkg::in_t in_i,
  output logic              empty,
  input  wire logic         pop,
  output ave_pkg::out_t     out_o
);

  ave_pkg::cmd_t cmd, head;
  logic          take, avail, done;

  assign take = push && !full;

  // front: classify and update state
  ave_front #(
    .MAX_NESTING (MAX_NESTING),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .item_i(in_i),
    .cmd_o (cmd)
  );

  // command queue
  ave_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (take),
    .wdata_i(cmd),
    .full_o (full),
    .rd_i   (done),
    .rdata_o(head),
    .avail_o(avail)
  );

  // back: byte emitter
  ave_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (head),
    .avail_i(avail),
    .done_o (done),
    .out_o  (out_o),
    .empty_o(empty),
    .pop_i  (pop)
  );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the AMQP value encoder against a behavioral predictor. Directed
// items cover each kind, the form limits, underflow and overflow. Random
// nested sequences follow, then every open composite is closed.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Nesting = ave_pkg::MaxNestingDef;
  localparam int unsigned Bytes   = ave_pkg::BufferBytesDef;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  ave_pkg::in_t  in_i = '0;
  ave_pkg::out_t out_o;
  logic quiet = 1'b0;

  always #10 clk_i = ~clk_i;

  amqp_value_encoder u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .in_i  (in_i),
    .empty (empty),
    .pop   (pop),
    .out_o (out_o)
  );

  // predicts the byte stream of the encoder and checks what comes out
  class value_encoder_scoreboard;
    ave_pkg::out_t expected_bytes[$];
    int unsigned   mismatches = 0;
    logic [16:0]   wpos = '0;
    int unsigned   depth = 0;
    logic [31:0]   fsize[Nesting];
    logic [31:0]   fcount[Nesting];
    logic [15:0]   fpos[Nesting];

    function ave_pkg::out_t mk(logic [7:0] b, logic [15:0] off, logic p,
                               ave_pkg::status_e st, logic l);
      ave_pkg::out_t r;
      r.data_byte   = b;
      r.byte_offset = off;
      r.is_patch    = p;
      r.status      = st;
      r.last        = l;
      return r;
    endfunction

    function void append_be(ref logic [7:0] b[$], input logic [63:0] v, input int nb);
      for (int i = nb - 1; i >= 0; i--) b.push_back(v[8*i +: 8]);
    endfunction

    function void append_ulong(ref logic [7:0] b[$], input logic [63:0] v);
      if (v == 64'd0) begin
        b.push_back(8'h44);
      end else if (v < 64'd256) begin
        b.push_back(8'h53);
        b.push_back(v[7:0]);
      end else begin
        b.push_back(8'h80);
        append_be(b, v, 8);
      end
    endfunction

    function void append_header(ref logic [7:0] b[$], input logic [31:0] len,
                                input logic [7:0] c8, input logic [7:0] c32);
      if (len < 32'd256) begin
        b.push_back(c8);
        b.push_back(len[7:0]);
      end else begin
        b.push_back(c32);
        append_be(b, {32'd0, len}, 4);
      end
    endfunction

    // work out the bytes of one accepted transaction
    function void note_item(ave_pkg::in_t it);
      logic [7:0]  b[$];
      logic [63:0] v;
      logic [31:0] u;
      logic [31:0] t32;
      logic [63:0] t64;
      int unsigned d;
      logic        counts;
      v = it.value;
      u = v[31:0];
      counts = 1'b1;
      if (it.kind == ave_pkg::KIND_END) begin
        if (depth == 0) begin
          expected_bytes.push_back(mk(8'h00, wpos[15:0], 1'b0, ave_pkg::ST_UNDERFLOW,
                                      1'b1));
          return;
        end
        d = depth - 1;
        append_be(b, {32'd0, fsize[d]}, 4);
        append_be(b, {32'd0, fcount[d]}, 4);
        for (int i = 0; i < 8; i++)
          expected_bytes.push_back(mk(b[i], 16'(fpos[d] + i), 1'b1, ave_pkg::ST_OK,
                                      i == 7));
        depth = d;
        if (d > 0) begin
          fsize[d-1]  += fsize[d] - 32'd4;
          fcount[d-1] += 32'd1;
        end
        return;
      end
      if ((it.kind == ave_pkg::KIND_LIST || it.kind == ave_pkg::KIND_MAP) &&
          depth >= Nesting) begin
        expected_bytes.push_back(mk(8'h00, wpos[15:0], 1'b0, ave_pkg::ST_OVERFLOW, 1'b1));
        return;
      end
      case (ave_pkg::kind_e'(it.kind))
        ave_pkg::KIND_DESC: begin
          b.push_back(8'h00);
          append_ulong(b, v);
          counts = 1'b0;
        end
        ave_pkg::KIND_NULL: b.push_back(8'h40);
        ave_pkg::KIND_BOOL: b.push_back((v != 0) ? 8'h41 : 8'h42);
        ave_pkg::KIND_UINT: begin
          if (u == 0) begin
            b.push_back(8'h43);
          end else if (u < 32'd256) begin
            b.push_back(8'h52);
            b.push_back(u[7:0]);
          end else begin
            b.push_back(8'h70);
            append_be(b, {32'd0, u}, 4);
          end
        end
        ave_pkg::KIND_ULONG: append_ulong(b, v);
        ave_pkg::KIND_INT: begin
          t32 = u + 32'd128;
          if (t32 < 32'd256) begin
            b.push_back(8'h54);
            b.push_back(u[7:0]);
          end else begin
            b.push_back(8'h71);
            append_be(b, {32'd0, u}, 4);
          end
        end
        ave_pkg::KIND_LONG: begin
          t64 = v + 64'd128;
          if (t64 < 64'd256) begin
            b.push_back(8'h55);
            b.push_back(v[7:0]);
          end else begin
            b.push_back(8'h81);
            append_be(b, v, 8);
          end
        end
        ave_pkg::KIND_TIME: begin
          b.push_back(8'h83);
          append_be(b, v, 8);
        end
        ave_pkg::KIND_BIN:  append_header(b, u, 8'hA0, 8'hB0);
        ave_pkg::KIND_STR:  append_header(b, u, 8'hA1, 8'hB1);
        ave_pkg::KIND_SYM:  append_header(b, u, 8'hA3, 8'hB3);
        ave_pkg::KIND_UUID: b.push_back(8'h98);
        ave_pkg::KIND_RAW: begin
          b.push_back(v[7:0]);
          counts = 1'b0;
        end
        default: begin
          b.push_back((it.kind == ave_pkg::KIND_MAP) ? 8'hD1 : 8'hD0);
          for (int i = 0; i < 8; i++) b.push_back(8'h00);
          counts = 1'b0;
        end
      endcase
      if (int'(wpos) + b.size() > Bytes) begin
        expected_bytes.push_back(mk(8'h00, wpos[15:0], 1'b0, ave_pkg::ST_FULL, 1'b1));
        return;
      end
      foreach (b[i])
        expected_bytes.push_back(mk(b[i], 16'(wpos + i), 1'b0, ave_pkg::ST_OK,
                                    i == b.size() - 1));
      if (depth > 0) begin
        fsize[depth-1] += b.size();
        if (counts) fcount[depth-1] += 32'd1;
      end
      if (it.kind == ave_pkg::KIND_LIST || it.kind == ave_pkg::KIND_MAP) begin
        fpos[depth]   = 16'(wpos + 1);
        fsize[depth]  = 32'd4;
        fcount[depth] = 32'd0;
        depth++;
      end
      wpos = 17'(wpos + b.size());
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH: %s", what);
    endtask

    // compare one accepted byte with the oldest expectation
    task check_byte(ave_pkg::out_t got);
      ave_pkg::out_t e;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %p", got));
        return;
      end
      e = expected_bytes.pop_front();
      if (got.data_byte != e.data_byte)
        report_mismatch($sformatf("data_byte %h, exp %h @%0d", got.data_byte,
                                  e.data_byte, e.byte_offset));
      if (got.byte_offset != e.byte_offset)
        report_mismatch($sformatf("byte_offset %0d, exp %0d", got.byte_offset,
                                  e.byte_offset));
      if (got.is_patch != e.is_patch)
        report_mismatch($sformatf("is_patch %b, exp %b @%0d", got.is_patch,
                                  e.is_patch, e.byte_offset));
      if (got.status != e.status)
        report_mismatch($sformatf("status %0d, exp %0d @%0d", got.status,
                                  e.status, e.byte_offset));
      if (got.last != e.last)
        report_mismatch($sformatf("last %b, exp %b @%0d", got.last, e.last,
                                  e.byte_offset));
    endtask
  endclass

  value_encoder_scoreboard sb = new();

  // send one transaction and hold it until taken
  task send(ave_pkg::kind_e k, logic [63:0] v);
    ave_pkg::in_t it;
    it.kind  = k;
    it.value = v;
    in_i <= it;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_item(it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 64'd0;
      1:       return 64'($urandom_range(1, 255));
      2:       return -64'($urandom_range(1, 129));
      3:       return {32'd0, 32'($urandom)};
      4:       return {32'($urandom), 32'($urandom)};
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  // one random element, composite boundary or header with payload
  task send_random(output int n);
    int unsigned    r, len;
    ave_pkg::kind_e k;
    r = $urandom_range(0, 99);
    n = 1;
    if (sb.depth > 0 && r < 12) begin
      send(ave_pkg::KIND_END, rand_value());
    end else if (r < 21 && sb.depth < Nesting) begin
      send(r[0] ? ave_pkg::KIND_MAP : ave_pkg::KIND_LIST, rand_value());
    end else if (r == 21) begin
      send(ave_pkg::KIND_END, rand_value());
    end else if (r < 35) begin
      k = ave_pkg::kind_e'($urandom_range(ave_pkg::KIND_BIN, ave_pkg::KIND_SYM));
      len = $urandom_range(0, 6);
      send(k, ($urandom_range(0, 3) == 0) ? rand_value() : 64'(len));
      for (int i = 0; i < len; i++)
        send(ave_pkg::KIND_RAW, {32'($urandom), 32'($urandom)});
      n += len;
    end else begin
      send(ave_pkg::kind_e'($urandom_range(ave_pkg::KIND_DESC, ave_pkg::KIND_UUID)),
           rand_value());
    end
  endtask

  // result side with random stall bursts
  initial begin
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_byte(out_o);
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    int sent, n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every kind and the form limits
    send(ave_pkg::KIND_END, 64'd0);
    send(ave_pkg::KIND_LIST, 64'd0);
    send(ave_pkg::KIND_DESC, 64'd0);
    send(ave_pkg::KIND_DESC, 64'd255);
    send(ave_pkg::KIND_DESC, '1);
    send(ave_pkg::KIND_NULL, 64'd0);
    send(ave_pkg::KIND_BOOL, 64'd0);
    send(ave_pkg::KIND_BOOL, 64'h8000_0000_0000_0000);
    send(ave_pkg::KIND_UINT, 64'hFFFF_FFFF_0000_0000);
    send(ave_pkg::KIND_UINT, 64'd255);
    send(ave_pkg::KIND_UINT, 64'd256);
    send(ave_pkg::KIND_ULONG, 64'd0);
    send(ave_pkg::KIND_ULONG, 64'd256);
    send(ave_pkg::KIND_INT, 64'h0000_0000_FFFF_FF80);
    send(ave_pkg::KIND_INT, 64'hFFFF_FFFF_FFFF_FF7F);
    send(ave_pkg::KIND_INT, 64'd127);
    send(ave_pkg::KIND_LONG, 64'hFFFF_FFFF_FFFF_FF80);
    send(ave_pkg::KIND_LONG, 64'd128);
    send(ave_pkg::KIND_MAP, 64'd0);
    send(ave_pkg::KIND_TIME, '1);
    send(ave_pkg::KIND_BIN, 64'd255);
    send(ave_pkg::KIND_STR, 64'hFFFF_FFFF_0000_0100);
    send(ave_pkg::KIND_SYM, 64'd1);
    send(ave_pkg::KIND_RAW, 64'hFFFF_FFFF_FFFF_FFAB);
    send(ave_pkg::KIND_UUID, 64'd0);
    send(ave_pkg::KIND_END, 64'd0);
    send(ave_pkg::KIND_END, 64'd0);

    // nest to the limit, one too deep, then unwind
    for (int i = 0; i <= Nesting; i++)
      send(i[0] ? ave_pkg::KIND_MAP : ave_pkg::KIND_LIST, 64'd0);
    for (int i = 0; i < Nesting; i++) send(ave_pkg::KIND_END, 64'd0);

    // random nested sequences
    sent = 0;
    while (sent < 260) begin
      send_random(n);
      sent += n;
    end

    // close everything without idling
    quiet = 1'b1;
    while (sb.depth > 0) send(ave_pkg::KIND_END, 64'd0);
    send(ave_pkg::KIND_NULL, 64'd0);
    send(ave_pkg::KIND_LIST, 64'd0);
    send(ave_pkg::KIND_END, 64'd0);
    send(ave_pkg::KIND_END, 64'd0);
    push <= 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
